// ===== design/acd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package acd_pkg;

    localparam int ALPHABET_DEPTH = 256;
    localparam int ADDR_W = (ALPHABET_DEPTH > 1) ? $clog2(ALPHABET_DEPTH) : 1;

    localparam int SYM_W     = 8;
    localparam int KEY_W     = 8;
    localparam int IDX_W     = 8;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int M_W       = 9;   // modulus up to 256
    localparam int T_W       = 10;  // signed bezout coefficient, |t| <= m
    localparam int DIVD_W    = 17;  // dividend magnitude up to 255 * 255
    localparam int CNT_W     = 5;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [M_W-1:0] M_MIN = M_W'(2);
    localparam logic [M_W-1:0] M_MAX = M_W'(ALPHABET_DEPTH);

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_DERIVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_DECRYPT = 2'd2;

    localparam logic [ST_W-1:0] ST_OK          = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_COPRIME = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND   = 2'd2;
    localparam logic [ST_W-1:0] ST_NO_KEY      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_A      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_B      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SIZE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EUC_TEST,
        S_EUC_DIV,
        S_EUC_MUL,
        S_EUC_UPD,
        S_EUC_FIX,
        S_SRCH,
        S_MOD_MUL,
        S_MOD_START,
        S_MOD_DIV,
        S_LOOK_RD,
        S_LOOK_DATA,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [M_W-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quot;
        logic [M_W-1:0]    rem;
    } t_div_rsp;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [SYM_W-1:0]  data;
    } t_mem_wr;

endpackage
`default_nettype wire

// ===== design/acd_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface acd_in_if
    import acd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [IDX_W-1:0] entry_index;
    logic [SYM_W-1:0] symbol_in;

    modport source (output valid, output opcode, output entry_index, output symbol_in,
                    input ready);
    modport sink (input valid, input opcode, input entry_index, input symbol_in,
                  output ready);
endinterface
`default_nettype wire

// ===== design/acd_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface acd_out_if
    import acd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol_out;
    logic [KEY_W-1:0] inverse_out;
    logic [ST_W-1:0]  status;

    modport source (output valid, output symbol_out, output inverse_out, output status,
                    input ready);
    modport sink (input valid, input symbol_out, input inverse_out, input status,
                  output ready);
endinterface
`default_nettype wire

// ===== design/affine_cipher_decrypt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Affine cipher decryptor over a loadable alphabet held in a single-port-write,
// registered-read symbol memory. A request carries one of three operations: a
// load writes one alphabet symbol and finishes; a derive runs extended Euclid
// on key_a and the modulus m (alphabet_size clamped to 2..256), each Euclid
// step dividing in the shared serial divider, then multiplying and updating;
// a decrypt scans the memory one entry per cycle for the lowest index holding
// the symbol, then reduces inverse * (index - key_b) modulo m in the same
// divider and reads the plain symbol back.
// One request is worked on at a time; the result sits in an output register,
// so the next request may be taken while the previous result waits. Writing
// key_a or alphabet_size drops the derived key, and a decrypt needs a fresh
// derive after that.
module affine_cipher_decrypt
    import acd_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    acd_in_if.sink              i_in,
    acd_out_if.source           o_out,
    input  wire                 i_cfg_we,
    input  wire [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [CFG_W-1:0]     i_cfg_data
);

    t_state n_state;
    t_state r_state;

    // configuration and key state
    logic [KEY_W-1:0] r_key_a;
    logic [KEY_W-1:0] r_key_b;
    logic [M_W-1:0]   r_alpha_size;
    logic             r_inv_valid;
    logic [KEY_W-1:0] r_inv_key;
    logic [M_W-1:0]   w_m;

    // euclid datapath
    logic [M_W-1:0]        r_prev_r;
    logic [M_W-1:0]        r_cur_r;
    logic signed [T_W-1:0] r_prev_t;
    logic signed [T_W-1:0] r_cur_t;
    logic [M_W-1:0]        r_q;
    logic [M_W-1:0]        r_nr;
    logic signed [2*T_W-1:0] r_prod_t;
    logic signed [T_W-1:0] w_nt;
    logic signed [T_W-1:0] w_t_fix;

    // search and reduce datapath
    logic [SYM_W-1:0]  r_sym;
    logic [M_W-1:0]    r_addr;
    logic              r_pend;
    logic [ADDR_W-1:0] r_cmp_idx;
    logic [ADDR_W-1:0] r_found;
    logic              r_neg;
    logic [DIVD_W-1:0] r_mag;
    logic [M_W-1:0]    r_l;
    logic signed [M_W-1:0]   w_diff;
    logic signed [2*M_W-1:0] w_prod;
    logic [M_W-1:0]    w_l;
    logic              w_issue;
    logic              w_hit;
    logic              w_last;

    // pending result and output register
    logic [SYM_W-1:0] r_res_sym;
    logic [ST_W-1:0]  r_res_status;
    logic             r_out_valid;
    logic [SYM_W-1:0] r_out_sym;
    logic [KEY_W-1:0] r_out_inv;
    logic [ST_W-1:0]  r_out_status;

    logic             w_accept;
    logic             w_out_free;
    logic             w_ld_idx_ok;

    t_div_req   w_div_req;
    t_div_rsp   w_div_rsp;
    t_mem_wr    w_mem_wr;
    logic [ADDR_W-1:0] w_raddr;
    logic [SYM_W-1:0]  w_rdata;

    acd_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (w_mem_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    acd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // modulus clamped into the legal range
    always_comb begin
        priority if (r_alpha_size < M_MIN) begin
            w_m = M_MIN;
        end else if (r_alpha_size > M_MAX) begin
            w_m = M_MAX;
        end else begin
            w_m = r_alpha_size;
        end
    end

    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_ld_idx_ok = ({1'b0, i_in.entry_index} < (IDX_W + 1)'(ALPHABET_DEPTH));

    // euclid step arithmetic; true values stay within the coefficient width
    assign w_nt    = r_prev_t - $signed(r_prod_t[T_W-1:0]);
    assign w_t_fix = r_prev_t[T_W-1] ? (r_prev_t + $signed({1'b0, w_m})) : r_prev_t;

    // signed product for the final reduction
    assign w_diff = $signed({1'b0, r_found}) - $signed({1'b0, r_key_b});
    assign w_prod = $signed({1'b0, r_inv_key}) * w_diff;

    // c-style remainder of a negative value brought into 0..m-1
    assign w_l = (r_neg && (w_div_rsp.rem != '0)) ? (w_m - w_div_rsp.rem) : w_div_rsp.rem;

    // search compare on the registered read data
    assign w_issue = (r_state == S_SRCH) && (r_addr < w_m);
    assign w_hit   = r_pend && (w_rdata == r_sym);
    assign w_last  = r_pend && ({1'b0, r_cmp_idx} == (w_m - M_W'(1)));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_in.opcode)
                        OP_DERIVE:  n_state = S_EUC_TEST;
                        OP_DECRYPT: n_state = r_inv_valid ? S_SRCH : S_FINISH;
                        default:    n_state = S_FINISH;
                    endcase
                end
            end
            S_EUC_TEST:  n_state = (r_cur_r == '0) ? S_EUC_FIX : S_EUC_DIV;
            S_EUC_DIV:   n_state = w_div_rsp.done ? S_EUC_MUL : S_EUC_DIV;
            S_EUC_MUL:   n_state = S_EUC_UPD;
            S_EUC_UPD:   n_state = S_EUC_TEST;
            S_EUC_FIX:   n_state = S_FINISH;
            S_SRCH: begin
                priority if (w_hit) begin
                    n_state = S_MOD_MUL;
                end else if (w_last) begin
                    n_state = S_FINISH;
                end
            end
            S_MOD_MUL:   n_state = S_MOD_START;
            S_MOD_START: n_state = S_MOD_DIV;
            S_MOD_DIV:   n_state = w_div_rsp.done ? S_LOOK_RD : S_MOD_DIV;
            S_LOOK_RD:   n_state = S_LOOK_DATA;
            S_LOOK_DATA: n_state = S_FINISH;
            S_FINISH:    n_state = w_out_free ? S_IDLE : S_FINISH;
            default:     n_state = S_IDLE;
        endcase
    end

    // outputs of the control
    always_comb begin
        i_in.ready = (r_state == S_IDLE);

        w_div_req = '0;
        unique case (r_state)
            S_EUC_TEST: begin
                w_div_req.start    = (r_cur_r != '0);
                w_div_req.dividend = DIVD_W'(r_prev_r);
                w_div_req.divisor  = r_cur_r;
            end
            S_MOD_START: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = r_mag;
                w_div_req.divisor  = w_m;
            end
            default: begin
                w_div_req = '0;
            end
        endcase

        w_mem_wr.we   = w_accept && (i_in.opcode == OP_LOAD) && w_ld_idx_ok;
        w_mem_wr.addr = i_in.entry_index[ADDR_W-1:0];
        w_mem_wr.data = i_in.symbol_in;

        w_raddr = (r_state == S_SRCH) ? r_addr[ADDR_W-1:0] : r_l[ADDR_W-1:0];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_key_a      <= KEY_W'(1);
            r_key_b      <= '0;
            r_alpha_size <= M_MAX;
            r_inv_valid  <= 1'b0;
            r_inv_key    <= '0;
            r_out_valid  <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_KEY_A: begin
                        r_key_a     <= i_cfg_data[KEY_W-1:0];
                        r_inv_valid <= 1'b0;
                    end
                    CFG_KEY_B: begin
                        r_key_b <= i_cfg_data[KEY_W-1:0];
                    end
                    CFG_ALPHA_SIZE: begin
                        r_alpha_size <= i_cfg_data[M_W-1:0];
                        r_inv_valid  <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end

            // derive outcome
            if (r_state == S_EUC_FIX) begin
                if (r_prev_r == M_W'(1)) begin
                    r_inv_valid <= 1'b1;
                    r_inv_key   <= w_t_fix[KEY_W-1:0];
                end else begin
                    r_inv_valid <= 1'b0;
                    r_inv_key   <= '0;
                end
            end

            // one read in flight per search cycle
            if (w_accept) begin
                r_pend <= 1'b0;
            end else if (r_state == S_SRCH) begin
                r_pend <= w_issue;
            end

            if ((r_state == S_FINISH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res_sym    <= '0;
            r_res_status <= ((i_in.opcode == OP_DECRYPT) && !r_inv_valid) ? ST_NO_KEY : ST_OK;
            r_sym        <= i_in.symbol_in;
            r_addr       <= '0;
            r_prev_r     <= w_m;
            r_cur_r      <= M_W'(r_key_a);
            r_prev_t     <= '0;
            r_cur_t      <= T_W'(1);
        end

        unique case (r_state)
            S_EUC_DIV: begin
                if (w_div_rsp.done) begin
                    r_q  <= w_div_rsp.quot[M_W-1:0];
                    r_nr <= w_div_rsp.rem;
                end
            end
            S_EUC_MUL: begin
                r_prod_t <= $signed({1'b0, r_q}) * r_cur_t;
            end
            S_EUC_UPD: begin
                r_prev_r <= r_cur_r;
                r_cur_r  <= r_nr;
                r_prev_t <= r_cur_t;
                r_cur_t  <= w_nt;
            end
            S_EUC_FIX: begin
                if (r_prev_r != M_W'(1)) begin
                    r_res_status <= ST_NOT_COPRIME;
                end
            end
            S_SRCH: begin
                if (w_issue) begin
                    r_cmp_idx <= r_addr[ADDR_W-1:0];
                    r_addr    <= r_addr + M_W'(1);
                end
                if (w_hit) begin
                    r_found <= r_cmp_idx;
                end else if (w_last) begin
                    r_res_status <= ST_NOT_FOUND;
                end
            end
            S_MOD_MUL: begin
                r_neg <= w_prod[2*M_W-1];
                r_mag <= w_prod[2*M_W-1] ? DIVD_W'(-w_prod) : DIVD_W'(w_prod);
            end
            S_MOD_DIV: begin
                if (w_div_rsp.done) begin
                    r_l <= w_l;
                end
            end
            S_LOOK_DATA: begin
                r_res_sym <= w_rdata;
            end
            default: begin
            end
        endcase

        if ((r_state == S_FINISH) && w_out_free) begin
            r_out_sym    <= r_res_sym;
            r_out_status <= r_res_status;
            r_out_inv    <= r_inv_valid ? r_inv_key : '0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.symbol_out  = r_out_sym;
    assign o_out.inverse_out = r_out_inv;
    assign o_out.status      = r_out_status;

endmodule
`default_nettype wire

// ===== design/acd_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module acd_mem
    import acd_pkg::*;
(
    input  wire              i_clk,
    input  t_mem_wr          i_wr,
    input  wire [ADDR_W-1:0] i_raddr,
    output logic [SYM_W-1:0] o_rdata
);

    logic [SYM_W-1:0] r_mem [ALPHABET_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== design/acd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module acd_div
    import acd_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    // restoring divider, one quotient bit per cycle
    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVD_W-1:0] r_quo;
    logic [M_W-1:0]    r_rem;
    logic [M_W-1:0]    r_dvs;
    logic [M_W:0]      w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_quo[DIVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], w_ge};
            r_rem <= w_ge ? M_W'(w_trial - {1'b0, r_dvs}) : w_trial[M_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule
`default_nettype wire
